[hdl/mctr_pkg.sv]
// Shared constants, types and font function of the LED matrix clock.
package mctr_pkg;

  localparam int unsigned PeriodW   = 20;
  localparam int unsigned SubsecW   = 20;
  localparam int unsigned SecondW   = 6;
  localparam int unsigned MinuteW   = 11;
  localparam int unsigned RowW      = 4;
  localparam int unsigned RowBitsW  = 16;

  localparam logic [PeriodW-1:0] PeriodReset = 20'd524288;
  localparam logic [20:0]        UsPerSecond = 21'd1000000;
  localparam logic [20:0]        UsTwoSecond = 21'd2000000;
  localparam logic [6:0]         SecPerMin   = 7'd60;
  localparam logic [MinuteW-1:0] MinPerDay   = 11'd1440;

  // Multiply-and-shift reciprocals for the exact ranges used here.
  localparam logic [10:0] RecipSixty = 11'd1093;
  localparam logic [7:0]  RecipTen   = 8'd205;

  localparam logic [0:0] OpTick = 1'b0;
  localparam logic [0:0] OpRead = 1'b1;

  localparam logic [14:0] Glyph [10] = '{
    15'd31599, 15'd25746, 15'd29671, 15'd29391, 15'd23497,
    15'd31183, 15'd31215, 15'd29257, 15'd31727, 15'd31695
  };

  typedef struct packed {
    logic [SubsecW-1:0] subsec;
    logic [SecondW-1:0] seconds;
    logic [MinuteW-1:0] minutes;
  } time_t;

  typedef struct packed {
    logic [RowBitsW-1:0] row_bits;
    logic [RowW-1:0]     row_echo;
    logic [MinuteW-1:0]  minute_of_day;
    logic [SecondW-1:0]  second_now;
  } result_t;

  function automatic logic [2:0] glyph_slice(logic [3:0] digit, logic [2:0] line);
    logic [14:0] g;
    logic [2:0]  s;
    g = (digit < 4'd10) ? Glyph[digit] : 15'd0;
    case (line)
      3'd0:    s = g[14:12];
      3'd1:    s = g[11:9];
      3'd2:    s = g[8:6];
      3'd3:    s = g[5:3];
      3'd4:    s = g[2:0];
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

[hdl/mctr_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface mctr_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] opcode;
  logic [3:0] row_select;

  modport source (output valid, output opcode, output row_select, input ready);
  modport sink (input valid, input opcode, input row_select, output ready);
endinterface

interface mctr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_bits;
  logic [3:0]  row_echo;
  logic [10:0] minute_of_day;
  logic [5:0]  second_now;

  modport source (output valid, output row_bits, output row_echo, output minute_of_day,
                  output second_now, input ready);
  modport sink (input valid, input row_bits, input row_echo, input minute_of_day,
                input second_now, output ready);
endinterface

[hdl/mctr_time.sv]
// Time-of-day registers, tick period register and tick carry chain.
module mctr_time
  import mctr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               period_we_i,
  input  logic [PeriodW-1:0] period_i,
  input  logic               tick_i,
  output time_t              cur_o,
  output time_t              nxt_o
);

  logic [PeriodW-1:0] period_q;
  time_t              time_q;
  logic [20:0]        sum;
  logic [1:0]         carry;
  logic [20:0]        sub_d;
  logic [6:0]         sec_sum;
  logic               min_inc;
  logic [MinuteW-1:0] min_sum;

  always_comb begin
    sum = 21'(time_q.subsec) + 21'(period_q);
    if (sum >= UsTwoSecond) begin
      carry = 2'd2;
      sub_d = sum - UsTwoSecond;
    end else if (sum >= UsPerSecond) begin
      carry = 2'd1;
      sub_d = sum - UsPerSecond;
    end else begin
      carry = 2'd0;
      sub_d = sum;
    end
    sec_sum = 7'(time_q.seconds) + 7'(carry);
    min_inc = (sec_sum >= SecPerMin);
    if (min_inc) begin
      sec_sum = sec_sum - SecPerMin;
    end
    min_sum = time_q.minutes + MinuteW'(min_inc);
    if (min_sum == MinPerDay) begin
      min_sum = '0;
    end
    nxt_o.subsec  = sub_d[SubsecW-1:0];
    nxt_o.seconds = sec_sum[SecondW-1:0];
    nxt_o.minutes = min_sum;
  end

  assign cur_o = time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
      time_q   <= '0;
    end else begin
      if (period_we_i) begin
        period_q <= period_i;
      end
      if (tick_i) begin
        time_q <= nxt_o;
      end
    end
  end

endmodule

[hdl/mctr_render.sv]
// Renders one row of the clock face from the current minutes and seconds.
module mctr_render
  import mctr_pkg::*;
(
  input  logic [MinuteW-1:0]  minutes_i,
  input  logic [SecondW-1:0]  seconds_i,
  input  logic [RowW-1:0]     row_i,
  output logic [RowBitsW-1:0] row_bits_o
);

  logic [21:0]        hour_prod;
  logic [4:0]         hours;
  logic [MinuteW-1:0] hour_mins;
  logic [5:0]         mins;
  logic [5:0]         value;
  logic [13:0]        tens_prod;
  logic [2:0]         tens;
  logic [5:0]         units;
  logic [2:0]         line;
  logic               digits_on;
  logic [6:0]         sec;
  logic [6:0]         row_w;
  logic [RowBitsW-1:0] bits;

  always_comb begin
    hour_prod = 22'(minutes_i) * 22'(RecipSixty);
    hours     = hour_prod[20:16];
    hour_mins = MinuteW'(hours) * MinuteW'(SecPerMin);
    mins      = 6'(minutes_i - hour_mins);

    digits_on = 1'b1;
    if (row_i inside {[4'd2:4'd6]}) begin
      value = 6'(hours);
      line  = 3'(row_i - 4'd2);
    end else if (row_i inside {[4'd9:4'd13]}) begin
      value = mins;
      line  = 3'(row_i - 4'd9);
    end else begin
      value     = '0;
      line      = '0;
      digits_on = 1'b0;
    end

    tens_prod = 14'(value) * 14'(RecipTen);
    tens      = tens_prod[13:11];
    units     = value - 6'(tens) * 6'd10;

    bits = '0;
    if (digits_on) begin
      bits[11:9] = glyph_slice(4'(tens), line);
      bits[6:4]  = glyph_slice(units[3:0], line);
    end

    sec   = 7'(seconds_i);
    row_w = 7'(row_i);
    for (int b = 0; b < RowBitsW; b++) begin
      if (row_i == 4'd0 && sec >= 7'(RowBitsW - b)) begin
        bits[b] = 1'b1;
      end
      if (row_i == 4'd15 && b >= 1 && sec >= 7'(b + 31)) begin
        bits[b] = 1'b1;
      end
    end
    if (row_i != 4'd0 && sec >= row_w + 7'd16) begin
      bits[0] = 1'b1;
    end
    if (row_i inside {[4'd2:4'd14]} && sec >= 7'd61 - row_w) begin
      bits[15] = 1'b1;
    end
    row_bits_o = bits;
  end

endmodule

[hdl/mctr_skid.sv]
// Result register with a skid entry so the input side keeps flowing.
module mctr_skid
  import mctr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  result_t          in_data_i,
  mctr_out_if.source       out_o
);

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    accept;
  logic    out_free;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= in_data_i;
      end
    end else if (accept) begin
      skid_q <= in_data_i;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.row_bits      = out_q.row_bits;
  assign out_o.row_echo      = out_q.row_echo;
  assign out_o.minute_of_day = out_q.minute_of_day;
  assign out_o.second_now    = out_q.second_now;

endmodule

[hdl/matrix_clock_time_and_row_render.sv]
// Top level of the LED matrix clock: time keeping and row rendering.
//
// Input items arrive on item_i (valid/ready). Opcode tick adds the tick period
// to the time of day; opcode read renders the row named by row_select.
// Every item gives exactly one result item on result_o, which carries the row
// bits, the row index and the minute and second after the item.
// A tick result shows zero row bits and a zero row index.
// The tick period is written through cfg_we_i and cfg_data_i; the user must do
// so only while idle; the block does not enforce it. Results are registered.
// Throughput is one item per cycle while the skid entry is empty, set by the
// single pass from the time registers through the carry chain or row renderer
// into the result register. When the receiver stalls, one further item is
// taken into a skid entry, and item_i.ready then falls until the result
// register drains. Reset clears the time to midnight, sets the tick period to
// 524288 us and empties the result stages.
module matrix_clock_time_and_row_render
  import mctr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PeriodW-1:0] cfg_data_i,
  mctr_in_if.sink            item_i,
  mctr_out_if.source         result_o
);

  logic    in_ready;
  logic    accept;
  logic    tick;
  time_t   cur_time;
  time_t   nxt_time;
  logic [RowBitsW-1:0] rendered;
  result_t result;

  assign item_i.ready = in_ready;
  assign accept       = item_i.valid && in_ready;
  assign tick         = accept && (item_i.opcode == OpTick);

  mctr_time u_time (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_we_i (cfg_we_i),
    .period_i    (cfg_data_i),
    .tick_i      (tick),
    .cur_o       (cur_time),
    .nxt_o       (nxt_time)
  );

  mctr_render u_render (
    .minutes_i  (cur_time.minutes),
    .seconds_i  (cur_time.seconds),
    .row_i      (item_i.row_select),
    .row_bits_o (rendered)
  );

  always_comb begin
    if (item_i.opcode == OpRead) begin
      result.row_bits      = rendered;
      result.row_echo      = item_i.row_select;
      result.minute_of_day = cur_time.minutes;
      result.second_now    = cur_time.seconds;
    end else begin
      result.row_bits      = '0;
      result.row_echo      = '0;
      result.minute_of_day = nxt_time.minutes;
      result.second_now    = nxt_time.seconds;
    end
  end

  mctr_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .in_data_i  (result),
    .out_o      (result_o)
  );

endmodule

[hdl/mctr_checker.sv]
// Port-level checks of the LED matrix clock and their binding to the top level.
module mctr_checker
  import mctr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [RowBitsW-1:0] row_bits_i,
  input logic [MinuteW-1:0]  minute_i,
  input logic [SecondW-1:0]  second_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result item dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(row_bits_i) && $stable(minute_i)
                                    && $stable(second_i))
    else $error("Result item changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> second_i < SecondW'(SecPerMin))
    else $error("Second count out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> minute_i < MinPerDay)
    else $error("Minute of day out of range.");

endmodule

bind matrix_clock_time_and_row_render mctr_checker u_mctr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .row_bits_i  (result_o.row_bits),
  .minute_i    (result_o.minute_of_day),
  .second_i    (result_o.second_now)
);

[test/matrix_clock_time_and_row_render_test.sv]
// Self-checking testbench for the LED matrix clock time keeper and row renderer.
module matrix_clock_time_and_row_render_test
  import mctr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {StepTick, StepRead, StepPeriod} step_e;

  typedef struct packed {
    step_e               kind;
    logic [PeriodW-1:0]  period;
    logic [RowW-1:0]     row;
    logic                known;
    result_t             want;
  } plan_row_t;

  localparam int unsigned MicrosPerSec  = 1000000;
  localparam int unsigned MinutesPerDay = 1440;
  localparam int unsigned RandomPhases  = 6;
  localparam int unsigned PhaseItems    = 155;

  localparam logic [14:0] DigitFont [10] = '{
    15'd31599, 15'd25746, 15'd29671, 15'd29391, 15'd23497,
    15'd31183, 15'd31215, 15'd29257, 15'd31727, 15'd31695
  };

  plan_row_t directed_plan [27] = '{
    '{StepRead,   20'd0,       4'd0,  1'b1, '{16'h0000, 4'd0,  11'd0, 6'd0}},
    '{StepRead,   20'd0,       4'd2,  1'b1, '{16'h0E70, 4'd2,  11'd0, 6'd0}},
    '{StepRead,   20'd0,       4'd15, 1'b1, '{16'h0000, 4'd15, 11'd0, 6'd0}},
    '{StepTick,   20'd0,       4'd0,  1'b1, '{16'h0000, 4'd0,  11'd0, 6'd0}},
    '{StepTick,   20'd0,       4'd0,  1'b1, '{16'h0000, 4'd0,  11'd0, 6'd1}},
    '{StepRead,   20'd0,       4'd0,  1'b1, '{16'h8000, 4'd0,  11'd0, 6'd1}},
    '{StepPeriod, 20'd902849,  4'd0,  1'b0, '0},
    '{StepTick,   20'd0,       4'd0,  1'b0, '0},
    '{StepPeriod, 20'd1048575, 4'd0,  1'b0, '0},
    '{StepTick,   20'd0,       4'd0,  1'b0, '0},
    '{StepPeriod, 20'd0,       4'd0,  1'b0, '0},
    '{StepTick,   20'd0,       4'd0,  1'b0, '0},
    '{StepPeriod, 20'd1,       4'd0,  1'b0, '0},
    '{StepTick,   20'd0,       4'd0,  1'b0, '0},
    '{StepRead,   20'd0,       4'd1,  1'b0, '0},
    '{StepRead,   20'd0,       4'd3,  1'b0, '0},
    '{StepRead,   20'd0,       4'd4,  1'b0, '0},
    '{StepRead,   20'd0,       4'd5,  1'b0, '0},
    '{StepRead,   20'd0,       4'd6,  1'b0, '0},
    '{StepRead,   20'd0,       4'd7,  1'b0, '0},
    '{StepRead,   20'd0,       4'd8,  1'b0, '0},
    '{StepRead,   20'd0,       4'd9,  1'b0, '0},
    '{StepRead,   20'd0,       4'd10, 1'b0, '0},
    '{StepRead,   20'd0,       4'd11, 1'b0, '0},
    '{StepRead,   20'd0,       4'd12, 1'b0, '0},
    '{StepRead,   20'd0,       4'd13, 1'b0, '0},
    '{StepRead,   20'd0,       4'd14, 1'b0, '0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [PeriodW-1:0] cfg_data_i;

  mctr_in_if  in_if ();
  mctr_out_if out_if ();

  matrix_clock_time_and_row_render u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (in_if),
    .result_o   (out_if)
  );

  always #2 clk_i = ~clk_i;

  int unsigned clock_subsec_us;
  int unsigned clock_second;
  int unsigned clock_minute;
  int unsigned tick_period;

  result_t pending_results [$];

  bit send_idle_on;
  bit recv_idle_on;
  int unsigned ticks_sent;
  int unsigned reads_sent;
  int unsigned period_writes;
  int unsigned results_checked;
  int unsigned day_wraps;
  int unsigned mismatch_count;

  function automatic logic [2:0] font_line(int unsigned digit, int unsigned line);
    logic [14:0] g;
    g = DigitFont[digit % 10];
    return g[3 * (4 - line) +: 3];
  endfunction

  function automatic logic [15:0] digit_pair(int unsigned value, int unsigned line);
    logic [15:0] bits;
    bits = '0;
    bits[11:9] = font_line(value / 10, line);
    bits[6:4]  = font_line(value % 10, line);
    return bits;
  endfunction

  function automatic logic [15:0] face_row(int unsigned row);
    logic [15:0] bits;
    int unsigned hours;
    int unsigned mins;
    bits  = '0;
    hours = clock_minute / 60;
    mins  = clock_minute % 60;
    if (row >= 2 && row <= 6) begin
      bits = digit_pair(hours, row - 2);
    end else if (row >= 9 && row <= 13) begin
      bits = digit_pair(mins, row - 9);
    end
    for (int unsigned s = 1; s <= clock_second; s++) begin
      if (s < 17) begin
        if (row == 0) bits[16 - s] = 1'b1;
      end else if (s < 32) begin
        if (row == s - 16) bits[0] = 1'b1;
      end else if (s < 47) begin
        if (row == 15) bits[s - 31] = 1'b1;
      end else begin
        if (row == 61 - s) bits[15] = 1'b1;
      end
    end
    return bits;
  endfunction

  function automatic void advance_clock();
    int unsigned sum;
    int unsigned secs;
    int unsigned mins;
    sum             = clock_subsec_us + tick_period;
    secs            = clock_second + sum / MicrosPerSec;
    clock_subsec_us = sum % MicrosPerSec;
    mins            = clock_minute + secs / 60;
    clock_second    = secs % 60;
    if (mins >= MinutesPerDay) day_wraps++;
    clock_minute    = mins % MinutesPerDay;
  endfunction

  function automatic result_t predict_face_item(logic [0:0] op, logic [RowW-1:0] row);
    result_t r;
    r = '0;
    if (op == OpTick) begin
      advance_clock();
    end else begin
      r.row_bits = face_row(row);
      r.row_echo = row;
    end
    r.minute_of_day = MinuteW'(clock_minute);
    r.second_now    = SecondW'(clock_second);
    return r;
  endfunction

  task automatic send_item(input logic [0:0] op, input logic [RowW-1:0] row,
                           input logic known, input result_t typed);
    int unsigned gap;
    result_t     predicted;
    gap = send_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.row_select <= row;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = predict_face_item(op, row);
    pending_results.push_back(known ? typed : predicted);
    if (op == OpTick) ticks_sent++;
    else reads_sent++;
  endtask

  task automatic write_period(input logic [PeriodW-1:0] value);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tick_period = value;
    period_writes++;
  endtask

  task automatic send_random_item(input int unsigned read_odds);
    logic [0:0]      op;
    logic [RowW-1:0] row;
    op  = ($urandom_range(0, read_odds - 1) == 0) ? OpRead : OpTick;
    row = RowW'($urandom_range(0, 15));
    send_item(op, row, 1'b0, '0);
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result item with none expected: row_bits %h row_echo %0d",
             out_if.row_bits, out_if.row_echo);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      if (out_if.row_bits !== want.row_bits) begin
        $error("row_bits: expected %h, got %h", want.row_bits, out_if.row_bits);
        mismatch_count++;
      end
      if (out_if.row_echo !== want.row_echo) begin
        $error("row_echo: expected %0d, got %0d", want.row_echo, out_if.row_echo);
        mismatch_count++;
      end
      if (out_if.minute_of_day !== want.minute_of_day) begin
        $error("minute_of_day: expected %0d, got %0d", want.minute_of_day,
               out_if.minute_of_day);
        mismatch_count++;
      end
      if (out_if.second_now !== want.second_now) begin
        $error("second_now: expected %0d, got %0d", want.second_now, out_if.second_now);
        mismatch_count++;
      end
    end
  endtask

  initial begin
    int unsigned stall;
    forever begin
      stall = recv_idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      check_result();
    end
  end

  initial begin
    logic [PeriodW-1:0] phase_period;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_data_i       <= '0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= OpTick;
    in_if.row_select <= '0;
    clock_subsec_us  = 0;
    clock_second     = 0;
    clock_minute     = 0;
    tick_period      = PeriodReset;
    send_idle_on     = 1'b1;
    recv_idle_on     = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      case (directed_plan[i].kind)
        StepTick: begin
          send_item(OpTick, '0, directed_plan[i].known, directed_plan[i].want);
        end
        StepRead: begin
          send_item(OpRead, directed_plan[i].row, directed_plan[i].known,
                    directed_plan[i].want);
        end
        StepPeriod: begin
          write_period(directed_plan[i].period);
        end
        default: begin
        end
      endcase
    end

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0:       phase_period = 20'd999999;
        1:       phase_period = 20'd1;
        2:       phase_period = PeriodW'($urandom_range(1, 999999));
        3:       phase_period = 20'hFFFFF;
        4:       phase_period = PeriodW'($urandom_range(0, 20'hFFFFF));
        default: phase_period = PeriodW'($urandom_range(500000, 999999));
      endcase
      send_idle_on = (phase != 1 && phase != 4);
      recv_idle_on = (phase != 2 && phase != 4);
      write_period(phase_period);
      repeat (PhaseItems) send_random_item(2);
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Sent %0d ticks and %0d row reads across %0d tick period settings.",
             ticks_sent, reads_sent, period_writes);
    $display("Checked %0d results; the time of day wrapped at midnight %0d time(s).",
             results_checked, day_wraps);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
hdl/mctr_pkg.sv
hdl/mctr_if.sv
hdl/mctr_time.sv
hdl/mctr_render.sv
hdl/mctr_skid.sv
hdl/matrix_clock_time_and_row_render.sv
hdl/mctr_checker.sv
test/matrix_clock_time_and_row_render_test.sv
